// File: design/vvnu_pkg.sv
// ----------------------------------------------------------------------------
// vvnu_pkg
// Shared types, widths, register indexes and saturation for the node update.
// ----------------------------------------------------------------------------
`default_nettype none

package vvnu_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int SCALE_BITS = 16;
	localparam int NUM_TYPES  = 4;
	localparam int TYPE_W     = 2;
	localparam int MAX_NODES  = 8;
	localparam int CNT_W      = 3;
	localparam int NPE_W      = 4;
	localparam int SCALE_W    = 17;
	localparam int GROUP_W    = 8;
	localparam int SUM_W      = 35;
	localparam int PROD_W     = 2 * DATA_W + 1;
	localparam int CPROD_W    = SUM_W + SCALE_W + 1;
	localparam int SAT_W      = PROD_W - FRAC_BITS + 1;
	localparam int NUM_LANES  = 3;
	localparam int REG_IDX_W  = 3;

	// register indexes on the configuration port
	localparam logic [REG_IDX_W-1:0] REG_DRIFT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KICK0 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KICK1 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KICK2 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KICK3 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_NPE   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SCALE = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_GROUP = 3'd7;

	localparam logic ACT_INITIAL = 1'b0;
	localparam logic ACT_FINAL   = 1'b1;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic active;
		logic drift;
	} lane_ctl_t;

	typedef struct packed {
		logic upd;
		logic initial_act;
	} merge_ctl_t;

	function automatic data_t sat_data(input logic signed [SAT_W-1:0] v);
		if ((&v[SAT_W-1:DATA_W-1]) || !(|v[SAT_W-1:DATA_W-1])) begin
			return v[DATA_W-1:0];
		end else if (v[SAT_W-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

// File: design/vvnu_lane.sv
// ----------------------------------------------------------------------------
// vvnu_lane
// One axis: half-step kick of the velocity, then drift of the position.
// ----------------------------------------------------------------------------
`default_nettype none

module vvnu_lane (
	input  wire logic                          clk,
	input  wire logic [vvnu_pkg::DATA_W-1:0]   kick,
	input  wire logic [vvnu_pkg::DATA_W-1:0]   dt,
	input  wire vvnu_pkg::lane_ctl_t           ctl,
	input  wire vvnu_pkg::data_t               force_in,
	input  wire vvnu_pkg::data_t               vel_in,
	input  wire vvnu_pkg::data_t               pos_in,
	output vvnu_pkg::data_t                    new_vel,
	output vvnu_pkg::data_t                    new_pos
);

	localparam int DW = vvnu_pkg::DATA_W;
	localparam int PW = vvnu_pkg::PROD_W;
	localparam int SW = vvnu_pkg::SAT_W;
	localparam int FB = vvnu_pkg::FRAC_BITS;

	logic signed [PW-1:0] kprod_s1;
	logic signed [PW-1:0] dprod_s3;
	vvnu_pkg::data_t      v_s1, x_s1, vnew_s2, x_s2, v_s3, x_s3, v_s4, xnew_s4;
	logic signed [SW-1:0] vsum, xsum;

	// floor shift is the arithmetic shift, taken as a part-select
	always_comb begin
		vsum = {{(SW-DW){v_s1[DW-1]}}, v_s1} + {kprod_s1[PW-1], kprod_s1[PW-1:FB]};
		xsum = {{(SW-DW){x_s3[DW-1]}}, x_s3} + {dprod_s3[PW-1], dprod_s3[PW-1:FB]};
	end

	always_ff @(posedge clk) begin
		kprod_s1 <= $signed({1'b0, kick}) * force_in;
		v_s1     <= vel_in;
		x_s1     <= pos_in;
		vnew_s2  <= ctl.active ? vvnu_pkg::sat_data(vsum) : v_s1;
		x_s2     <= x_s1;
		dprod_s3 <= $signed({1'b0, dt}) * vnew_s2;
		v_s3     <= vnew_s2;
		x_s3     <= x_s2;
		xnew_s4  <= ctl.drift ? vvnu_pkg::sat_data(xsum) : x_s3;
		v_s4     <= v_s3;
	end

	assign new_vel = v_s4;
	assign new_pos = xnew_s4;

endmodule

`default_nettype wire

// File: design/vvnu_merge.sv
// ----------------------------------------------------------------------------
// vvnu_merge
// Element position sums per lane, node count and scaled centroid.
// ----------------------------------------------------------------------------
`default_nettype none

module vvnu_merge (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire vvnu_pkg::merge_ctl_t             ctl,
	input  wire logic [vvnu_pkg::NPE_W-1:0]       npe,
	input  wire logic [vvnu_pkg::SCALE_W-1:0]     scale,
	input  wire vvnu_pkg::data_t                  pos [vvnu_pkg::NUM_LANES],
	output vvnu_pkg::data_t                       centroid [vvnu_pkg::NUM_LANES],
	output logic                                  centroid_valid
);

	localparam int DW = vvnu_pkg::DATA_W;
	localparam int SU = vvnu_pkg::SUM_W;
	localparam int CW = vvnu_pkg::CPROD_W;
	localparam int SW = vvnu_pkg::SAT_W;
	localparam int SB = vvnu_pkg::SCALE_BITS;
	localparam int NW = vvnu_pkg::NPE_W;
	localparam int NL = vvnu_pkg::NUM_LANES;

	logic signed [SU-1:0] sum_q   [NL];
	logic signed [SU-1:0] ctot    [NL];
	logic signed [SU-1:0] ctot_s5 [NL];
	logic signed [CW-1:0] cprod_s6 [NL];
	logic [vvnu_pkg::CNT_W-1:0] cnt_q;
	logic [NW-1:0]        npe_eff;
	logic                 last;
	logic                 cvalid_s5, cvalid_s6;

	always_comb begin
		if (npe == '0) begin
			npe_eff = NW'(1);
		end else if (npe > NW'(vvnu_pkg::MAX_NODES)) begin
			npe_eff = NW'(vvnu_pkg::MAX_NODES);
		end else begin
			npe_eff = npe;
		end
		last = (NW'(cnt_q) + NW'(1)) >= npe_eff;
		for (int c = 0; c < NL; c++) begin
			ctot[c] = sum_q[c] + (ctl.initial_act ?
				{{(SU-DW){pos[c][DW-1]}}, pos[c]} : SU'(0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			cvalid_s5 <= 1'b0;
			cvalid_s6 <= 1'b0;
			for (int c = 0; c < NL; c++) begin
				sum_q[c] <= '0;
			end
		end else begin
			cvalid_s6 <= cvalid_s5;
			if (ctl.upd) begin
				cnt_q     <= last ? '0 : cnt_q + 1'b1;
				cvalid_s5 <= last && ctl.initial_act;
				for (int c = 0; c < NL; c++) begin
					sum_q[c] <= last ? '0 : ctot[c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NL; c++) begin
			if (ctl.upd) begin
				ctot_s5[c] <= ctot[c];
			end
			cprod_s6[c] <= ctot_s5[c] * $signed({1'b0, scale});
		end
	end

	always_comb begin
		for (int c = 0; c < NL; c++) begin
			centroid[c] = cvalid_s6 ? vvnu_pkg::sat_data(
				{{(SW-CW+SB){cprod_s6[c][CW-1]}}, cprod_s6[c][CW-1:SB]}) : '0;
		end
	end

	assign centroid_valid = cvalid_s6;

endmodule

`default_nettype wire

// File: design/velocity_verlet_node_update.sv
// ----------------------------------------------------------------------------
// velocity_verlet_node_update
// Velocity Verlet kick/drift of one node per item, three axis lanes side by
// side, with a merge stage that forms the element centroid.
// ----------------------------------------------------------------------------
// the result is registered on the master side; a new item is accepted only once
// the last one has left the last stage; the lane pipeline (two multiplies,
//   two saturating adds) and the centroid multiply run one node at a time
// a waiting result holds the last stage until taken; input waits meanwhile
// reset: arst_n clears the registers to their defaults, the node count and
//   the element sums; no clearing pass
`default_nettype none

module velocity_verlet_node_update (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	// group_bits, particle_type, force_x/y/z, vel_x/y/z, pos_x/y/z, zero pad
	input  wire logic [303:0]   s_tdata,
	// action
	input  wire logic [0:0]     s_tuser,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	// new_vel_x/y/z, new_pos_x/y/z, centroid_x/y/z
	output logic [287:0]        m_tdata,
	// centroid_valid
	output logic [0:0]          m_tuser,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [31:0]    cfg_data
);

	localparam int DW = vvnu_pkg::DATA_W;
	localparam int NL = vvnu_pkg::NUM_LANES;
	localparam int FO = vvnu_pkg::GROUP_W + vvnu_pkg::TYPE_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL_K, ST_ADD_V, ST_MUL_D, ST_ADD_X, ST_ACC, ST_MUL_C, ST_OUT
	} state_t;

	state_t state_q;

	logic [DW-1:0]                     drift_q;
	logic [DW-1:0]                     kick_q [vvnu_pkg::NUM_TYPES];
	logic [vvnu_pkg::NPE_W-1:0]        npe_q;
	logic [vvnu_pkg::SCALE_W-1:0]      scale_q;
	logic [vvnu_pkg::GROUP_W-1:0]      group_q;
	logic [vvnu_pkg::TYPE_W-1:0]       kick_idx;

	logic                              action_s0;
	logic [DW-1:0]                     kick_s0;
	vvnu_pkg::lane_ctl_t               lane_ctl_s0;
	vvnu_pkg::data_t                   force_s0 [NL];
	vvnu_pkg::data_t                   vel_s0   [NL];
	vvnu_pkg::data_t                   pos_s0   [NL];
	vvnu_pkg::data_t                   new_vel  [NL];
	vvnu_pkg::data_t                   new_pos  [NL];
	vvnu_pkg::data_t                   centroid [NL];
	logic                              centroid_valid;
	vvnu_pkg::merge_ctl_t              merge_ctl;

	vvnu_pkg::data_t                   out_vel_q  [NL];
	vvnu_pkg::data_t                   out_pos_q  [NL];
	vvnu_pkg::data_t                   out_cent_q [NL];
	logic                              out_cv_q;
	logic                              out_valid_q;

	logic in_acc, out_load, out_free, grp_hit;
	logic [vvnu_pkg::TYPE_W-1:0] in_type;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = (state_q == ST_OUT) && out_free;
	assign kick_idx  = vvnu_pkg::TYPE_W'(cfg_index - vvnu_pkg::REG_KICK0);
	assign in_type   = s_tdata[FO-1:vvnu_pkg::GROUP_W];
	assign grp_hit   = |(s_tdata[vvnu_pkg::GROUP_W-1:0] & group_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_q <= '0;
			for (int t = 0; t < vvnu_pkg::NUM_TYPES; t++) begin
				kick_q[t] <= '0;
			end
			npe_q   <= vvnu_pkg::NPE_W'(1);
			scale_q <= vvnu_pkg::SCALE_W'(65536);
			group_q <= vvnu_pkg::GROUP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vvnu_pkg::REG_DRIFT: drift_q <= cfg_data;
				vvnu_pkg::REG_KICK0, vvnu_pkg::REG_KICK1,
				vvnu_pkg::REG_KICK2, vvnu_pkg::REG_KICK3: kick_q[kick_idx] <= cfg_data;
				vvnu_pkg::REG_NPE:   npe_q   <= cfg_data[vvnu_pkg::NPE_W-1:0];
				vvnu_pkg::REG_SCALE: scale_q <= cfg_data[vvnu_pkg::SCALE_W-1:0];
				vvnu_pkg::REG_GROUP: group_q <= cfg_data[vvnu_pkg::GROUP_W-1:0];
				default: ;
			endcase
		end
	end

	// input item register, held until the next accept
	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_s0         <= s_tuser[0];
			kick_s0           <= kick_q[in_type];
			lane_ctl_s0.active <= grp_hit;
			lane_ctl_s0.drift  <= grp_hit && (s_tuser[0] == vvnu_pkg::ACT_INITIAL);
			for (int c = 0; c < NL; c++) begin
				force_s0[c] <= s_tdata[FO + DW*c +: DW];
				vel_s0[c]   <= s_tdata[FO + DW*(NL+c) +: DW];
				pos_s0[c]   <= s_tdata[FO + DW*(2*NL+c) +: DW];
			end
		end
	end

	for (genvar g = 0; g < NL; g++) begin : g_lane
		vvnu_lane u_lane (
			.clk      (clk),
			.kick     (kick_s0),
			.dt       (drift_q),
			.ctl      (lane_ctl_s0),
			.force_in (force_s0[g]),
			.vel_in   (vel_s0[g]),
			.pos_in   (pos_s0[g]),
			.new_vel  (new_vel[g]),
			.new_pos  (new_pos[g])
		);
	end

	assign merge_ctl.upd         = (state_q == ST_ACC);
	assign merge_ctl.initial_act = (action_s0 == vvnu_pkg::ACT_INITIAL);

	vvnu_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (merge_ctl),
		.npe            (npe_q),
		.scale          (scale_q),
		.pos            (new_pos),
		.centroid       (centroid),
		.centroid_valid (centroid_valid)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:  if (in_acc) begin
					state_q <= ST_MUL_K;
				end
				ST_MUL_K: state_q <= ST_ADD_V;
				ST_ADD_V: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= ST_ADD_X;
				ST_ADD_X: state_q <= ST_ACC;
				ST_ACC:   state_q <= ST_MUL_C;
				ST_MUL_C: state_q <= ST_OUT;
				ST_OUT:   if (out_free) begin
					state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cv_q <= centroid_valid;
			for (int c = 0; c < NL; c++) begin
				out_vel_q[c]  <= new_vel[c];
				out_pos_q[c]  <= new_pos[c];
				out_cent_q[c] <= centroid[c];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_cv_q;
	assign m_tdata  = {out_cent_q[2], out_cent_q[1], out_cent_q[0],
		out_pos_q[2], out_pos_q[1], out_pos_q[0],
		out_vel_q[2], out_vel_q[1], out_vel_q[0]};

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input accepted while an item is in flight");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("result load did not raise valid");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && m_tvalid && !m_tready) |=> state_q == ST_OUT)
		else $error("last stage left while output blocked");

	a_centroid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[287:192] == '0))
		else $error("centroid nonzero without centroid valid");

endmodule

`default_nettype wire
